FILE: rtl/mm4_pkg.sv
package mm4_pkg;

	localparam int DIM           = 4;
	localparam int CELLS         = DIM * DIM;
	localparam int IDX_W         = $clog2(CELLS);
	localparam int POS_W         = $clog2(DIM);
	localparam int DATA_W        = 32;
	localparam int PROD_W        = 2 * DATA_W;
	// four products summed: two guard bits over the product width
	localparam int ACC_W         = PROD_W + 2;
	localparam int FRAC_BITS_DEF = 16;

	// operand select on the load channel
	localparam logic SEL_A = 1'b0;
	localparam logic SEL_B = 1'b1;

	// tag that travels with each operand pair through the MAC
	typedef struct packed {
		logic             vld;
		logic             first;   // k = 0: restart the sum
		logic             last_k;  // k = 3: sum complete
		logic [IDX_W-1:0] elem;    // row-major result index
	} mm4_tag_t;

	// one finished result element
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] value;
		logic              sat;
		logic [IDX_W-1:0]  elem;
	} mm4_res_t;

endpackage

FILE: rtl/mm4_mac.sv
module mm4_mac #(
	parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [mm4_pkg::DATA_W-1:0] a_s1,
	input  logic signed [mm4_pkg::DATA_W-1:0] b_s1,
	input  mm4_pkg::mm4_tag_t              tag_s1,
	output mm4_pkg::mm4_res_t              res_s4
);
	import mm4_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	mm4_tag_t                 tag_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic signed [ACC_W-1:0]  prod_ext;
	mm4_tag_t                 tag_s3;
	logic signed [ACC_W-1:0]  shifted;
	logic                     fits;

	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	// arithmetic shift of the exact sum rounds towards minus infinity
	assign shifted = acc_s3 >>> FRAC_BITS;
	assign fits    = (&shifted[ACC_W-1:DATA_W-1]) | ~(|shifted[ACC_W-1:DATA_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			res_s4 <= '0;
		end else begin
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
			res_s4.vld   <= tag_s3.vld & tag_s3.last_k;
			res_s4.elem  <= tag_s3.elem;
			res_s4.sat   <= ~fits;
			if (fits) begin
				res_s4.value <= shifted[DATA_W-1:0];
			end else if (acc_s3[ACC_W-1]) begin
				res_s4.value <= {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				res_s4.value <= {1'b0, {(DATA_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (tag_s2.vld) begin
			acc_s3 <= tag_s2.first ? prod_ext : acc_s3 + prod_ext;
		end
	end

endmodule

FILE: rtl/matrix4x4_multiply.sv
// 4x4 fixed-point matrix multiplier, C = A * B, signed Q16.16, row-major.
//
// Input channel (in_valid / in_stall): each transfer writes one element of
// A (which_matrix = 0) or B (which_matrix = 1) at (row_index, col_index).
// Loads are taken one per cycle while in_stall is low. A transfer with
// compute_now set stores its element and then starts the multiply;
// in_stall stays high while the operand reads for the 16 results are issued.
//
// Output channel (out_valid / out_stall): 16 transfers in row-major order,
// last_element on the final one, saturated when a sum was clipped.
// Each element needs four reads of both operand memories (one read port
// each). Reads of the next element follow unless the queue credit holds
// them; results pass the read, product, sum and result registers in turn.
//
// A 2-entry output queue plus a credit count holds the issue of further
// elements while the receiver stalls; nothing is dropped. Loads for the
// next multiply are taken while the last results still drain.
// Reset clears control only; operand memories are undefined until loaded.
module matrix4x4_multiply #(
	parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              which_matrix,
	input  logic [mm4_pkg::POS_W-1:0]         row_index,
	input  logic [mm4_pkg::POS_W-1:0]         col_index,
	input  logic signed [mm4_pkg::DATA_W-1:0] element_value,
	input  logic                              compute_now,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mm4_pkg::DATA_W-1:0] product_value,
	output logic [mm4_pkg::POS_W-1:0]         out_row,
	output logic [mm4_pkg::POS_W-1:0]         out_col,
	output logic                              saturated,
	output logic                              last_element
);
	import mm4_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] elem_q;
	logic [POS_W-1:0] k_q;
	logic [1:0]       slots_q;   // elements started and not yet transferred out

	logic [DATA_W-1:0] mem_a [CELLS];
	logic [DATA_W-1:0] mem_b [CELLS];

	logic signed [DATA_W-1:0] rd_a_s1;
	logic signed [DATA_W-1:0] rd_b_s1;
	mm4_tag_t                 tag_s1;
	mm4_res_t                 res_s4;

	mm4_res_t         fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	logic             in_acc;
	logic [IDX_W-1:0] wr_idx;
	logic             pop;
	logic             credit_ok;
	logic             issue;
	logic             start;
	logic [IDX_W-1:0] ra;
	logic [IDX_W-1:0] rb;

	assign in_stall  = (state_q == ST_RUN);
	assign in_acc    = in_valid & ~in_stall;
	assign wr_idx    = {row_index, col_index};

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid & ~out_stall;

	// a new element may start only if its result has a queue slot waiting
	assign credit_ok = (slots_q != 2'd2) | pop;
	assign issue     = (state_q == ST_RUN) & ((k_q != '0) | credit_ok);
	assign start     = issue & (k_q == '0);

	// A[r][k] and B[k][c] for result (r, c)
	assign ra = {elem_q[IDX_W-1:POS_W], k_q};
	assign rb = {k_q, elem_q[POS_W-1:0]};

	// operand memories: written by loads; the registered read is used during compute only
	always_ff @(posedge clk) begin
		if (in_acc && which_matrix == SEL_A) begin
			mem_a[wr_idx] <= element_value;
		end
		rd_a_s1 <= mem_a[ra];
	end

	always_ff @(posedge clk) begin
		if (in_acc && which_matrix == SEL_B) begin
			mem_b[wr_idx] <= element_value;
		end
		rd_b_s1 <= mem_b[rb];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			elem_q  <= '0;
			k_q     <= '0;
			tag_s1  <= '0;
		end else begin
			tag_s1.vld    <= issue;
			tag_s1.first  <= (k_q == '0);
			tag_s1.last_k <= (k_q == POS_W'(DIM-1));
			tag_s1.elem   <= elem_q;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && compute_now) begin
						state_q <= ST_RUN;
						elem_q  <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						k_q <= k_q + 1'b1;
						if (k_q == POS_W'(DIM-1)) begin
							elem_q <= elem_q + 1'b1;
							if (elem_q == IDX_W'(CELLS-1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	mm4_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.a_s1  (rd_a_s1),
		.b_s1  (rd_b_s1),
		.tag_s1(tag_s1),
		.res_s4(res_s4)
	);

	// credits and output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= '0;
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			slots_q <= slots_q + {1'b0, start} - {1'b0, pop};
			cnt_q   <= cnt_q + {1'b0, res_s4.vld} - {1'b0, pop};
			if (res_s4.vld) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_s4.vld) begin
			fifo_q[wr_ptr_q] <= res_s4;
		end
	end

	assign product_value = fifo_q[rd_ptr_q].value;
	assign saturated     = fifo_q[rd_ptr_q].sat;
	assign out_row       = fifo_q[rd_ptr_q].elem[IDX_W-1:POS_W];
	assign out_col       = fifo_q[rd_ptr_q].elem[POS_W-1:0];
	assign last_element  = (fifo_q[rd_ptr_q].elem == IDX_W'(CELLS-1));

	// checks
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_s4.vld |-> ((cnt_q != 2'd2) || pop))
		else $error("result queue overrun");

	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= slots_q)
		else $error("queued results exceed started elements");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && k_q == POS_W'(DIM-1) && elem_q == IDX_W'(CELLS-1)) |=> !in_stall)
		else $error("sequencer did not return to idle");

	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !in_acc)
		else $error("load accepted during operand reads");

endmodule
